// File: sv/lbtc_pkg.sv
// Shared types, constants and tables for the line brightness temperature cell block.
`timescale 1ns / 1ps
`default_nettype none
package lbtc_pkg;

    // Mean is the running sum shifted right by log2 of the cell count
    localparam int LOG2_CELL_COUNT = 21;

    localparam logic [16:0] LOG2E_Q16 = 17'd94548;
    localparam logic [9:0]  K1000     = 10'd1000;
    localparam logic [16:0] ONE_Q16   = 17'h10000;

    typedef enum logic [1:0] {
        CFG_AMPLITUDE  = 2'd0,
        CFG_ONE_PLUS_Z = 2'd1,
        CFG_RAD_TEMP   = 2'd2,
        CFG_USE_SPIN   = 2'd3
    } lbtc_cfg_idx_t;

    typedef struct packed {
        logic signed [31:0] density_contrast;
        logic [16:0]        neutral_frac;
        logic [31:0]        spin_temp;
        logic               last_cell;
    } lbtc_in_t;

    typedef struct packed {
        logic signed [31:0] brightness_temperature;
        logic [31:0]        optical_depth;
        logic signed [31:0] mean_brightness;
        logic               error_flag;
        logic               is_last;
    } lbtc_out_t;

    typedef enum logic [4:0] {
        S_IDLE, S_P1, S_BASE, S_NLO, S_NHI, S_DIVT, S_DIVT_W, S_TAU, S_Y, S_EXP,
        S_EXPF, S_M1, S_M2, S_DIVB, S_DIVB_W, S_BT_ON, S_BT_OFF, S_SUM, S_OUT
    } lbtc_state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_P1, OP_BASE, OP_NLO, OP_NHI, OP_DIVT, OP_TAU, OP_Y,
        OP_EXP, OP_EXPF, OP_M1, OP_M2, OP_DIVB, OP_BT_ON, OP_BT_OFF, OP_SUM, OP_OUT
    } lbtc_op_t;

    typedef struct packed {
        lbtc_op_t   op;
        logic [3:0] exp_idx;
    } lbtc_cmd_t;

    typedef struct packed {
        logic mode;
        logic base_neg;
        logic div_busy;
        logic out_free;
    } lbtc_stat_t;

    // 2^-(2^-(i+1)) in Q0.30
    function automatic logic [29:0] pow2_frac(input logic [3:0] idx);
        logic [29:0] v;
        case (idx)
            4'd0:    v = 30'd759250125;
            4'd1:    v = 30'd902905651;
            4'd2:    v = 30'd984625593;
            4'd3:    v = 30'd1028218693;
            4'd4:    v = 30'd1050733751;
            4'd5:    v = 30'd1062175491;
            4'd6:    v = 30'd1067942999;
            4'd7:    v = 30'd1070838486;
            4'd8:    v = 30'd1072289173;
            4'd9:    v = 30'd1073015253;
            4'd10:   v = 30'd1073378478;
            4'd11:   v = 30'd1073560135;
            4'd12:   v = 30'd1073650976;
            4'd13:   v = 30'd1073696399;
            4'd14:   v = 30'd1073719111;
            4'd15:   v = 30'd1073730467;
            default: v = 30'd759250125;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// File: sv/lbtc_div.sv
// Restoring divider: 32 quotient bits of num * 2^16 / den, one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module lbtc_div (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] num,
    input  wire logic [41:0] den,
    output logic             busy,
    output logic             ovf,
    output logic [31:0]      quo
);
    logic        busy_reg, busy_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [41:0] rem_reg, rem_next;
    logic [31:0] q_reg, q_next;
    logic [41:0] den_reg, den_next;
    logic        ovf_reg, ovf_next;
    logic [42:0] trial, diff;
    logic        ge;

    assign trial = {rem_reg, q_reg[31]};
    assign ge    = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        den_next  = den_reg;
        ovf_next  = ovf_reg;
        if (start) begin
            // quotient must fit 32 bits; a zero divisor fails this too
            ovf_next  = num >= {6'd0, den, 16'd0};
            rem_next  = num[57:16];
            q_next    = {num[15:0], 16'd0};
            den_next  = den;
            cnt_next  = 5'd0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = ge ? diff[41:0] : trial[41:0];
            q_next   = {q_reg[30:0], ge};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        den_reg <= den_next;
        ovf_reg <= ovf_next;
    end

    assign busy = busy_reg;
    assign ovf  = ovf_reg;
    assign quo  = q_reg;
endmodule
`default_nettype wire

// File: sv/lbtc_dp.sv
// Datapath: configuration, per-cell arithmetic, running sum and output register.
`timescale 1ns / 1ps
`default_nettype none
module lbtc_dp #(
    parameter int LOG2_CELLS = lbtc_pkg::LOG2_CELL_COUNT
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire lbtc_pkg::lbtc_cmd_t cmd,
    output lbtc_pkg::lbtc_stat_t   stat,
    input  wire lbtc_pkg::lbtc_in_t  s_data,
    output lbtc_pkg::lbtc_out_t    m_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [31:0]       cfg_data
);
    import lbtc_pkg::*;

    logic [31:0] amp_reg, opz_reg, rad_reg;
    logic        mode_reg;
    lbtc_in_t    in_reg;
    logic [32:0] p1_reg;
    logic [41:0] ts1000_reg;
    logic [47:0] tradz_reg, dmag_reg;
    logic        dneg_reg, neg_reg;
    logic [48:0] base_reg;
    logic [55:0] nlo_reg;
    logic [63:0] n_reg;
    logic        tovf_reg;
    logic [31:0] tau_reg;
    logic [32:0] y_reg;
    logic [30:0] e_reg;
    logic [16:0] onem_reg;
    logic [47:0] pm_reg;
    logic [57:0] mm_reg;
    logic [31:0] bt_reg;
    logic        err_reg;
    logic [63:0] sum_reg;
    logic        sticky_reg;
    lbtc_out_t   out_reg;
    logic        m_valid_reg;

    logic [31:0] dc_u, dmag_in, opd;
    logic        neg_raw, neg_eff;
    logic [48:0] p1_full;
    logic [63:0] tradz_full;
    logic [64:0] base_full;
    logic [56:0] nhi;
    logic [80:0] full81;
    logic [48:0] y_full;
    logic [60:0] e_full;
    logic [30:0] e_sh;
    logic [16:0] ne;
    logic [64:0] pm_full;
    logic [47:0] ts48;
    logic [31:0] cap, q_mag, bt_mag;
    logic        bt_ovf;
    logic signed [63:0] sh;
    logic        mean_hi, mean_lo;
    logic [31:0] mean_val;
    logic        div_start, div_busy, div_ovf;
    logic [63:0] div_num;
    logic [41:0] div_den;
    logic [31:0] div_q;

    // 1 + delta as sign and magnitude
    always_comb begin
        dc_u    = in_reg.density_contrast;
        dmag_in = ~dc_u + 32'd1;
        if (dc_u[31]) begin
            neg_raw = dmag_in > 32'h0001_0000;
            opd     = neg_raw ? dmag_in - 32'h0001_0000 : 32'h0001_0000 - dmag_in;
        end else begin
            neg_raw = 1'b0;
            opd     = dc_u + 32'h0001_0000;
        end
    end

    assign neg_eff    = neg_reg && (base_reg != 49'd0);
    assign p1_full    = 49'(amp_reg) * 49'(in_reg.neutral_frac);
    assign tradz_full = 64'(rad_reg) * 64'(opz_reg);
    assign base_full  = 65'(p1_reg) * 65'(opd);
    assign nhi        = 57'(base_reg[48:24]) * 57'(opz_reg);
    assign full81     = {nhi, 24'd0} + 81'(nlo_reg);
    assign y_full     = 49'(tau_reg) * 49'(LOG2E_Q16);
    assign e_full     = 61'(e_reg) * 61'(pow2_frac(cmd.exp_idx));
    assign e_sh       = e_reg >> y_reg[20:16];
    assign ne         = (|y_reg[32:21]) ? 17'd0 : e_sh[30:14];
    assign pm_full    = 65'(dmag_reg) * 65'(onem_reg);
    assign ts48       = 48'(in_reg.spin_temp);

    // brightness saturation, shared by both modes
    always_comb begin
        cap    = (cmd.op == OP_BT_ON ? dneg_reg : neg_eff) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        if (cmd.op == OP_BT_ON) begin
            bt_ovf = div_ovf || (div_q > cap);
            q_mag  = div_q;
        end else begin
            bt_ovf = base_reg > 49'(cap);
            q_mag  = base_reg[31:0];
        end
        bt_mag = bt_ovf ? cap : q_mag;
    end

    assign sh       = $signed(sum_reg) >>> LOG2_CELLS;
    assign mean_hi  = sh > $signed(64'h0000_0000_7FFF_FFFF);
    assign mean_lo  = sh < $signed(64'hFFFF_FFFF_8000_0000);
    assign mean_val = mean_hi ? 32'h7FFF_FFFF : (mean_lo ? 32'h8000_0000 : sh[31:0]);

    assign div_start = (cmd.op == OP_DIVT) || (cmd.op == OP_DIVB);
    assign div_num   = (cmd.op == OP_DIVT) ? n_reg : {6'd0, mm_reg};
    assign div_den   = (cmd.op == OP_DIVT) ? ts1000_reg : {10'd0, opz_reg};

    lbtc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .busy    (div_busy),
        .ovf     (div_ovf),
        .quo     (div_q)
    );

    // configuration and control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            amp_reg     <= 32'd0;
            opz_reg     <= 32'h0001_0000;
            rad_reg     <= 32'd0;
            mode_reg    <= 1'b0;
            sum_reg     <= 64'd0;
            sticky_reg  <= 1'b0;
            err_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_AMPLITUDE:  amp_reg  <= cfg_data;
                    CFG_ONE_PLUS_Z: opz_reg  <= cfg_data;
                    CFG_RAD_TEMP:   rad_reg  <= cfg_data;
                    CFG_USE_SPIN:   mode_reg <= cfg_data[0];
                    default:        amp_reg  <= amp_reg;
                endcase
            end
            if (cmd.op == OP_OUT) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (cmd.op)
                OP_LOAD: err_reg <= 1'b0;
                OP_P1: begin
                    if (mode_reg && in_reg.spin_temp == 32'd0) begin
                        err_reg <= 1'b1;
                    end
                end
                OP_NLO: begin
                    if (neg_eff) begin
                        err_reg <= 1'b1;
                    end
                end
                OP_TAU: begin
                    if (tovf_reg || div_ovf) begin
                        err_reg <= 1'b1;
                    end
                end
                OP_BT_ON, OP_BT_OFF: begin
                    if (bt_ovf) begin
                        err_reg <= 1'b1;
                    end
                end
                OP_SUM: sum_reg <= sum_reg + {{32{bt_reg[31]}}, bt_reg};
                OP_OUT: begin
                    if (in_reg.last_cell) begin
                        sum_reg    <= 64'd0;
                        sticky_reg <= 1'b0;
                    end else begin
                        sticky_reg <= sticky_reg | err_reg;
                    end
                end
                default: err_reg <= err_reg;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                in_reg   <= s_data;
                tau_reg  <= 32'd0;
                tovf_reg <= 1'b0;
            end
            OP_P1: begin
                p1_reg     <= p1_full[48:16];
                ts1000_reg <= 42'(in_reg.spin_temp) * 42'(K1000);
                tradz_reg  <= tradz_full[63:16];
            end
            OP_BASE: begin
                base_reg <= base_full[64:16];
                neg_reg  <= neg_raw;
                dneg_reg <= tradz_reg > ts48;
                dmag_reg <= (tradz_reg > ts48) ? tradz_reg - ts48 : ts48 - tradz_reg;
            end
            OP_NLO: nlo_reg <= 56'(base_reg[23:0]) * 56'(opz_reg);
            OP_NHI: begin
                n_reg    <= full81[79:16];
                tovf_reg <= full81[80];
            end
            OP_TAU: tau_reg <= (tovf_reg || div_ovf) ? 32'hFFFF_FFFF : div_q;
            OP_Y: begin
                y_reg <= y_full[48:16];
                e_reg <= 31'h4000_0000;
            end
            OP_EXP: begin
                if (y_reg[~cmd.exp_idx]) begin
                    e_reg <= e_full[60:30];
                end
            end
            OP_EXPF: onem_reg <= ONE_Q16 - ne;
            OP_M1:   pm_reg   <= pm_full[63:16];
            OP_M2:   mm_reg   <= 58'(pm_reg) * 58'(K1000);
            OP_BT_ON: bt_reg <= (dneg_reg && bt_mag != 32'd0) ? ~bt_mag + 32'd1 : bt_mag;
            OP_BT_OFF: bt_reg <= neg_eff ? ~bt_mag + 32'd1 : bt_mag;
            OP_OUT: begin
                out_reg.brightness_temperature <= bt_reg;
                out_reg.optical_depth          <= tau_reg;
                out_reg.mean_brightness        <= in_reg.last_cell ? mean_val : 32'd0;
                out_reg.error_flag             <= sticky_reg | err_reg |
                                                  (in_reg.last_cell & (mean_hi | mean_lo));
                out_reg.is_last                <= in_reg.last_cell;
            end
            default: bt_reg <= bt_reg;
        endcase
    end

    assign stat.mode     = mode_reg;
    assign stat.base_neg = neg_eff;
    assign stat.div_busy = div_busy;
    assign stat.out_free = !m_valid_reg || m_ready;

    assign m_data    = out_reg;
    assign m_valid   = m_valid_reg;
    assign cfg_ready = 1'b1;

    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_OUT |-> (!m_valid_reg || m_ready))
        else $error("result written over a pending result");
    a_box_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_OUT && in_reg.last_cell) |=> (sum_reg == 64'd0 && !sticky_reg))
        else $error("sum or sticky error not cleared after last cell");
    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");
    a_out_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_OUT |=> m_valid_reg)
        else $error("result lost");
endmodule
`default_nettype wire

// File: sv/lbtc_ctrl.sv
// Controller: sequences the datapath through one cell.
`timescale 1ns / 1ps
`default_nettype none
module lbtc_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire lbtc_pkg::lbtc_stat_t stat,
    output lbtc_pkg::lbtc_cmd_t     cmd
);
    import lbtc_pkg::*;

    lbtc_state_t state_reg, state_next;
    logic [3:0]  cnt_reg, cnt_next;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            S_IDLE:   if (s_valid) begin
                          state_next = S_P1;
                      end
            S_P1:     state_next = S_BASE;
            S_BASE:   state_next = stat.mode ? S_NLO : S_BT_OFF;
            S_NLO:    state_next = stat.base_neg ? S_Y : S_NHI;
            S_NHI:    state_next = S_DIVT;
            S_DIVT:   state_next = S_DIVT_W;
            S_DIVT_W: if (!stat.div_busy) begin
                          state_next = S_TAU;
                      end
            S_TAU:    state_next = S_Y;
            S_Y: begin
                state_next = S_EXP;
                cnt_next   = 4'd0;
            end
            S_EXP: begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15) begin
                    state_next = S_EXPF;
                end
            end
            S_EXPF:   state_next = S_M1;
            S_M1:     state_next = S_M2;
            S_M2:     state_next = S_DIVB;
            S_DIVB:   state_next = S_DIVB_W;
            S_DIVB_W: if (!stat.div_busy) begin
                          state_next = S_BT_ON;
                      end
            S_BT_ON:  state_next = S_SUM;
            S_BT_OFF: state_next = S_SUM;
            S_SUM:    state_next = S_OUT;
            S_OUT:    if (stat.out_free) begin
                          state_next = S_IDLE;
                      end
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd.exp_idx = cnt_reg;
        s_ready     = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                cmd.op  = s_valid ? OP_LOAD : OP_NONE;
            end
            S_P1:     cmd.op = OP_P1;
            S_BASE:   cmd.op = OP_BASE;
            S_NLO:    cmd.op = OP_NLO;
            S_NHI:    cmd.op = OP_NHI;
            S_DIVT:   cmd.op = OP_DIVT;
            S_TAU:    cmd.op = OP_TAU;
            S_Y:      cmd.op = OP_Y;
            S_EXP:    cmd.op = OP_EXP;
            S_EXPF:   cmd.op = OP_EXPF;
            S_M1:     cmd.op = OP_M1;
            S_M2:     cmd.op = OP_M2;
            S_DIVB:   cmd.op = OP_DIVB;
            S_BT_ON:  cmd.op = OP_BT_ON;
            S_BT_OFF: cmd.op = OP_BT_OFF;
            S_SUM:    cmd.op = OP_SUM;
            S_OUT:    cmd.op = stat.out_free ? OP_OUT : OP_NONE;
            default:  cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= 4'd0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end
endmodule
`default_nettype wire

// File: sv/line_brightness_temperature_cell_top.sv
// Top level of the line brightness temperature cell block.
// Operation: one cell at a time; a request is accepted only in the idle state, after the
// previous cell has written its result, which may wait in the output register until taken.
// The spin temperature mode runs two divider passes (one when the base is negative) and the
// 16-step exponential; with the mode off the base product goes straight to saturation.
// Reset: synchronous, active low; resets control, configuration, running sum, sticky error and output valid.
`timescale 1ns / 1ps
`default_nettype none
module line_brightness_temperature_cell_top #(
    parameter int LOG2_CELLS = lbtc_pkg::LOG2_CELL_COUNT
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire lbtc_pkg::lbtc_in_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output lbtc_pkg::lbtc_out_t      m_data,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [31:0]         cfg_data
);
    import lbtc_pkg::*;

    // command and status between sequencer and datapath
    lbtc_cmd_t  cmd;
    lbtc_stat_t stat;

    // Sequencer: accept a request only when idle, then step the datapath through the base
    // product and, in spin temperature mode, optical depth, exponential and brightness division.
    lbtc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Datapath: hold configuration, compute one cell, accumulate the box sum and
    // hold the finished result in an output register so the next request can enter
    // while it waits.
    lbtc_dp #(
        .LOG2_CELLS (LOG2_CELLS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_data    (s_data),
        .m_data    (m_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );
endmodule
`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for the line brightness temperature cell block.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import lbtc_pkg::*;

    localparam bit [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam bit [63:0] POS_LIMIT = 64'h7FFF_FFFF;
    localparam bit [63:0] NEG_LIMIT = 64'h8000_0000;
    localparam int DRAIN_CYCLES = 200;

    // Brightness predictor and store of expected cell results
    class brightness_scoreboard;
        bit [31:0] amplitude;
        bit [31:0] opz;
        bit [31:0] trad_today;
        bit        spin_mode;
        bit [63:0] sum;
        bit        sticky;
        lbtc_out_t pending_q[$];
        int        errors;
        bit [63:0] frac_tbl[16];

        function new();
            amplitude = 0;
            opz = 32'h10000;
            trad_today = 0;
            spin_mode = 0;
            sum = 0;
            sticky = 0;
            errors = 0;
            frac_tbl = '{759250125, 902905651, 984625593, 1028218693,
                         1050733751, 1062175491, 1067942999, 1070838486,
                         1072289173, 1073015253, 1073378478, 1073560135,
                         1073650976, 1073696399, 1073719111, 1073730467};
        endfunction

        function void write_reg(lbtc_cfg_idx_t idx, bit [31:0] val);
            case (idx)
                CFG_AMPLITUDE:  amplitude = val;
                CFG_ONE_PLUS_Z: opz = val;
                CFG_RAD_TEMP:   trad_today = val;
                CFG_USE_SPIN:   spin_mode = val[0];
            endcase
        endfunction

        // Q16.16 product of magnitudes, truncated and clamped
        function bit [63:0] qmul(bit [63:0] a, bit [63:0] b, bit [63:0] cap, inout bit ovf);
            bit [127:0] p;
            p = {64'd0, a} * {64'd0, b};
            if (p[127:80] != 0) begin
                ovf = 1;
                return cap;
            end
            if (p[79:16] > cap) begin
                ovf = 1;
                return cap;
            end
            return p[79:16];
        endfunction

        function bit [63:0] qdiv(bit [63:0] n, bit [63:0] d, bit [63:0] cap, inout bit ovf);
            bit [63:0] q;
            bit [63:0] r;
            bit [63:0] res;
            if (d == 0) begin
                ovf = 1;
                return cap;
            end
            q = n / d;
            if (q > (cap >> 16)) begin
                ovf = 1;
                return cap;
            end
            r = n % d;
            res = (q << 16) + ((r << 16) / d);
            if (res > cap) begin
                ovf = 1;
                return cap;
            end
            return res;
        endfunction

        // exp(-tau) in Q1.16 as a power of two
        function bit [63:0] decay(bit [63:0] tau);
            bit [63:0] y;
            bit [63:0] ip;
            bit [63:0] e;
            y = (tau * 64'd94548) >> 16;
            ip = y >> 16;
            e = 64'd1 << 30;
            if (ip >= 32) return 0;
            for (int i = 0; i < 16; i++)
                if (y[15 - i]) e = (e * frac_tbl[i]) >> 30;
            e = e >> ip;
            return e >> 14;
        endfunction

        function void note_cell(lbtc_in_t c);
            bit [31:0] dbits;
            bit [63:0] dmag, opd, base, tau, n, one_minus, trad, tdiff, m, q;
            bit [31:0] bt;
            bit [31:0] mean;
            bit neg, err, ovf, tovf, bovf, dneg;
            lbtc_out_t r;
            dbits = c.density_contrast;
            err = 0; ovf = 0; tovf = 0; bovf = 0;
            tau = 0;
            mean = 0;
            // 1 + delta as sign and magnitude
            if (dbits[31]) begin
                dmag = {32'd0, ~dbits} + 1;
                neg = dmag > 65536;
                opd = neg ? dmag - 65536 : 65536 - dmag;
            end else begin
                neg = 0;
                opd = {32'd0, dbits} + 65536;
            end
            base = qmul(qmul({32'd0, amplitude}, {47'd0, c.neutral_frac}, ALL_ONES, ovf),
                        opd, ALL_ONES, ovf);
            if (base == 0) neg = 0;
            if (spin_mode) begin
                if (c.spin_temp == 0) err = 1;
                if (neg) begin
                    err = 1;
                end else begin
                    n = qmul(base, {32'd0, opz}, ALL_ONES, tovf);
                    tau = qdiv(n, {32'd0, c.spin_temp} * 64'd1000, 64'hFFFF_FFFF, tovf);
                    if (tovf) begin
                        tau = 64'hFFFF_FFFF;
                        err = 1;
                    end
                end
                one_minus = 65536 - decay(tau);
                trad = qmul({32'd0, trad_today}, {32'd0, opz}, ALL_ONES, bovf);
                dneg = trad > c.spin_temp;
                tdiff = dneg ? trad - c.spin_temp : c.spin_temp - trad;
                m = qmul(tdiff, one_minus, ALL_ONES, bovf) * 64'd1000;
                m = qdiv(m, {32'd0, opz}, dneg ? NEG_LIMIT : POS_LIMIT, bovf);
                if (bovf) err = 1;
                if (m == 0) dneg = 0;
                bt = dneg ? -m[31:0] : m[31:0];
            end else begin
                if (ovf || base > (neg ? NEG_LIMIT : POS_LIMIT)) begin
                    base = neg ? NEG_LIMIT : POS_LIMIT;
                    err = 1;
                end
                bt = neg ? -base[31:0] : base[31:0];
            end
            sum = sum + {{32{bt[31]}}, bt};
            if (c.last_cell) begin
                if (sum[63]) begin
                    q = ~((~sum) >> LOG2_CELL_COUNT);
                    if (q < 64'hFFFF_FFFF_8000_0000) begin
                        q = 64'hFFFF_FFFF_8000_0000;
                        err = 1;
                    end
                end else begin
                    q = sum >> LOG2_CELL_COUNT;
                    if (q > POS_LIMIT) begin
                        q = POS_LIMIT;
                        err = 1;
                    end
                end
                mean = q[31:0];
            end
            if (err) sticky = 1;
            r.brightness_temperature = bt;
            r.optical_depth = tau[31:0];
            r.mean_brightness = mean;
            r.error_flag = sticky;
            r.is_last = c.last_cell;
            pending_q.push_back(r);
            if (c.last_cell) begin
                sum = 0;
                sticky = 0;
            end
        endfunction

        function void check_result(lbtc_out_t got);
            lbtc_out_t exp_r;
            if (pending_q.size() == 0) begin
                $error("unexpected result %h", got);
                errors++;
                return;
            end
            exp_r = pending_q.pop_front();
            if (got.brightness_temperature !== exp_r.brightness_temperature) begin
                $error("brightness_temperature: expected %h, got %h",
                       exp_r.brightness_temperature, got.brightness_temperature);
                errors++;
            end
            if (got.optical_depth !== exp_r.optical_depth) begin
                $error("optical_depth: expected %h, got %h",
                       exp_r.optical_depth, got.optical_depth);
                errors++;
            end
            if (got.mean_brightness !== exp_r.mean_brightness) begin
                $error("mean_brightness: expected %h, got %h",
                       exp_r.mean_brightness, got.mean_brightness);
                errors++;
            end
            if (got.error_flag !== exp_r.error_flag) begin
                $error("error_flag: expected %b, got %b", exp_r.error_flag, got.error_flag);
                errors++;
            end
            if (got.is_last !== exp_r.is_last) begin
                $error("is_last: expected %b, got %b", exp_r.is_last, got.is_last);
                errors++;
            end
        endfunction
    endclass

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    lbtc_in_t   s_data;
    logic       m_valid;
    logic       m_ready;
    lbtc_out_t  m_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    logic [31:0] cfg_data;

    brightness_scoreboard sb;
    bit no_idle;   // phase-wide switch that turns off all gaps and stalls

    line_brightness_temperature_cell_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Stall the result side in random bursts
    int stall_left = 0;
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else begin
            stall_left <= idle_len();
            m_ready <= 1'b1;
        end
    end

    // Check every accepted result against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
    end

    task automatic send_cell(input lbtc_in_t c);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= c;
        // hold the request until the handshake completes
        do @(posedge aclk); while (!s_ready);
        sb.note_cell(c);
    endtask

    task automatic write_reg(input lbtc_cfg_idx_t idx, input bit [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    // Drain outstanding results, then let the datapath settle before a register write
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic setup(input bit [31:0] amp, input bit [31:0] opz, input bit [31:0] rad,
                         input bit mode);
        write_reg(CFG_AMPLITUDE, amp);
        write_reg(CFG_ONE_PLUS_Z, opz);
        write_reg(CFG_RAD_TEMP, rad);
        write_reg(CFG_USE_SPIN, {31'd0, mode});
    endtask

    function automatic lbtc_in_t mk_cell(input int d, input int x, input bit [31:0] ts,
                                         input bit last);
        lbtc_in_t c;
        c.density_contrast = d;
        c.neutral_frac = x[16:0];
        c.spin_temp = ts;
        c.last_cell = last;
        return c;
    endfunction

    function automatic lbtc_in_t rand_cell();
        lbtc_in_t c;
        int r;
        r = $urandom_range(0, 9);
        // mostly physical overdensities, some full-range and some around delta = -1
        if (r < 5) c.density_contrast = $urandom_range(0, 5 * 65536) - 65536;
        else if (r < 8) c.density_contrast = $urandom;
        else c.density_contrast = $urandom_range(0, 4096) - 67584;
        c.neutral_frac = 17'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 65536)
                                                         : $urandom_range(0, 131071));
        r = $urandom_range(0, 9);
        if (r == 0) c.spin_temp = 0;
        else if (r < 6) c.spin_temp = $urandom_range(1, 200 * 65536);
        else c.spin_temp = $urandom;
        c.last_cell = ($urandom_range(0, 24) == 0);
        return c;
    endfunction

    task automatic directed_cells();
        send_cell(mk_cell(0, 65536, 32'h0064_0000, 0));
        send_cell(mk_cell(32'sh7FFF_FFFF, 65536, 32'h0064_0000, 0));
        send_cell(mk_cell(32'sh8000_0000, 65536, 32'h0064_0000, 0));
        send_cell(mk_cell(-65536, 65536, 32'h0064_0000, 0));
        send_cell(mk_cell(-65537, 40000, 32'h0064_0000, 0));
        send_cell(mk_cell(65536, 0, 32'h0064_0000, 0));
        send_cell(mk_cell(65536, 131071, 32'hFFFF_FFFF, 0));
        send_cell(mk_cell(32768, 65536, 32'h0, 0));
        send_cell(mk_cell(32768, 65536, 32'h1, 0));
        send_cell(mk_cell(12345, 30000, 32'h0002_0000, 1));
        send_cell(mk_cell(0, 65536, 32'h0064_0000, 1));
    endtask

    initial begin
        bit [31:0] amp, opz, rad;
        bit mode;
        sb = new();
        no_idle = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_AMPLITUDE;
        cfg_data = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: realistic constants, both modes
        setup(32'h001B_0000, 32'h000A_0000, 32'd178586, 1'b0);
        directed_cells();
        drain();
        write_reg(CFG_USE_SPIN, 32'd1);
        directed_cells();
        drain();

        // Random phases: fixed settings first (realistic, then extremes), then random settings
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin amp = 32'h001B_0000; opz = 32'h0010_0000; rad = 32'd178586; mode = 1; end
                1: begin amp = 32'hFFFF_FFFF; opz = 32'hFFFF_FFFF; rad = 32'hFFFF_FFFF; mode = 1; end
                2: begin amp = 0; opz = 32'h0001_0000; rad = 0; mode = 1; end
                3: begin amp = 32'hFFFF_FFFF; opz = 32'h0001_0000; rad = 0; mode = 0; end
                default: begin
                    amp = ($urandom_range(0, 1)) ? $urandom : $urandom_range(0, 100 * 65536);
                    opz = ($urandom_range(0, 1)) ? $urandom_range(65536, 32'hFFFF_FFFF)
                                                 : $urandom_range(65536, 40 * 65536);
                    rad = ($urandom_range(0, 1)) ? $urandom : $urandom_range(0, 5 * 65536);
                    mode = 1'($urandom_range(0, 1));
                end
            endcase
            setup(amp, opz, rad, mode);
            no_idle = (ph == 5);
            for (int i = 0; i < 190; i++) send_cell(rand_cell());
            drain();
        end
        no_idle = 0;

        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end
endmodule
`default_nettype wire

// File: line_brightness_temperature_cell_top.f
sv/lbtc_pkg.sv
sv/lbtc_div.sv
sv/lbtc_dp.sv
sv/lbtc_ctrl.sv
sv/line_brightness_temperature_cell_top.sv
tb/testbench.sv
